// ===== design/chws_pkg.sv =====
// chws_pkg: shared types and constants for the contour height/width selector
// request structs for the vertex and result channels, register indexes, reset values
// no dependencies
`default_nettype none

package chws_pkg;

  localparam int COORD_W = 12;   // width of the coordinate fields on the ports
  localparam int INDEX_W = 8;    // width of the reported contour order number
  localparam int SUM_W   = 40;   // shoelace accumulator, wraps modulo 2^40
  localparam int AREA_W  = 24;   // min_area register width
  localparam int CFG_W   = 24;   // widest configuration register
  localparam int CFG_A_W = 2;    // configuration index width
  localparam int CNT_W   = 9;    // contour counter, holds 0..256
  localparam int CNT_CAP = 256;  // hard cap on contours per frame

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_MIN_HEIGHT = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_MAX_WIDTH  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_MIN_AREA   = 2'd2;

  // configuration reset values
  localparam logic [COORD_W-1:0] MIN_HEIGHT_RST = 12'd200;
  localparam logic [COORD_W-1:0] MAX_WIDTH_RST  = 12'd150;
  localparam logic [AREA_W-1:0]  MIN_AREA_RST   = 24'd500;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               contour_end;
    logic               frame_end;
  } in_req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] best_index;
    logic [COORD_W-1:0] best_width;
    logic [COORD_W-1:0] top_y;
    logic [COORD_W-1:0] bottom_y;
  } out_req_t;

endpackage

`default_nettype wire

// ===== design/contour_height_width_select.sv =====
// contour_height_width_select: per-contour y span, shoelace area and width = area/height; keeps
// the widest qualifying contour of a frame; depends on chws_pkg (structs, indexes, reset values)
// per request: a first vertex is stored, later ones take two multiply steps on the shared 12x12
// multiplier; a contour end takes up to 4 multiply steps, magnitude, qualify, 12 divide steps,
// update, close (divide, update only if it qualifies); frame end adds emit, held by out_stall
// reset: synchronous, restores register defaults and clears contour and frame state
`default_nettype none

module contour_height_width_select #(
  parameter int COORD_BITS   = 12,
  parameter int IMAGE_HEIGHT = 480,
  parameter int MAX_CONTOURS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire chws_pkg::in_req_t             in_req,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output chws_pkg::out_req_t                 out_req,
  input  wire logic                          cfg_we,
  input  wire logic [chws_pkg::CFG_A_W-1:0]  cfg_addr,
  input  wire logic [chws_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int CW    = (COORD_BITS < chws_pkg::COORD_W) ? COORD_BITS : chws_pkg::COORD_W;
  localparam int YW    = chws_pkg::COORD_W;
  localparam int SW    = chws_pkg::SUM_W;
  localparam int PW    = 2 * CW;
  localparam int QW    = chws_pkg::COORD_W;   // quotient bits kept (width < 4096)
  localparam int DW    = YW + 1;              // divisor 2*height
  localparam int RW    = DW + QW;             // remainder bits while dividing
  localparam int NW    = chws_pkg::CNT_W;
  localparam int LIMIT = (MAX_CONTOURS < chws_pkg::CNT_CAP) ? MAX_CONTOURS : chws_pkg::CNT_CAP;
  localparam int STW   = $clog2(QW);

  localparam logic [YW-1:0] MIN_Y_RST = YW'(IMAGE_HEIGHT);
  localparam logic [NW-1:0] CNT_LIMIT = NW'(LIMIT);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_A, S_MUL_B, S_CLS_A, S_CLS_B,
    S_MAG, S_QUAL, S_DIV, S_UPD, S_END, S_EMIT
  } state_t;

  // control state
  state_t                          state_r, state_nxt;
  logic [YW-1:0]                   min_height_r, min_height_nxt;
  logic [YW-1:0]                   max_width_r, max_width_nxt;
  logic [chws_pkg::AREA_W-1:0]     min_area_r, min_area_nxt;
  logic [YW-1:0]                   run_min_r, run_min_nxt;
  logic [YW-1:0]                   run_max_r, run_max_nxt;
  logic [SW-1:0]                   sum_r, sum_nxt;
  logic                            at_start_r, at_start_nxt;
  logic [NW-1:0]                   cnt_r, cnt_nxt;
  logic                            best_valid_r, best_valid_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // payload
  logic [CW-1:0]                   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CW-1:0]                   first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic [CW-1:0]                   prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic                            end_r, end_nxt, fend_r, fend_nxt;
  logic [SW-1:0]                   mag_r, mag_nxt;
  logic [YW-1:0]                   height_r, height_nxt;
  logic [RW-1:0]                   dsh_r, dsh_nxt;
  logic [QW-1:0]                   quot_r, quot_nxt;
  logic [STW-1:0]                  step_r, step_nxt;
  logic [chws_pkg::INDEX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [QW-1:0]                   best_w_r, best_w_nxt;
  logic [YW-1:0]                   best_top_r, best_top_nxt;
  logic [YW-1:0]                   best_bot_r, best_bot_nxt;
  chws_pkg::out_req_t              out_r, out_nxt;

  // shared multiply-accumulate unit
  logic [CW-1:0]                   mul_a, mul_b;
  logic                            mul_sub;
  logic [PW-1:0]                   mul_prod;
  logic [SW-1:0]                   mac_add, mac_sum;

  // datapath helpers
  logic [CW-1:0]                   in_x, in_y;
  logic [YW-1:0]                   in_y_ext;
  logic [DW-1:0]                   div_v;
  logic                            qual;
  logic [RW:0]                     trial;

  always_comb begin
    unique case (state_r)
      S_MUL_A: begin
        mul_a = prev_x_r; mul_b = cur_y_r; mul_sub = 1'b0;
      end
      S_MUL_B: begin
        mul_a = cur_x_r; mul_b = prev_y_r; mul_sub = 1'b1;
      end
      S_CLS_A: begin
        mul_a = cur_x_r; mul_b = first_y_r; mul_sub = 1'b0;
      end
      S_CLS_B: begin
        mul_a = first_x_r; mul_b = cur_y_r; mul_sub = 1'b1;
      end
      default: begin
        mul_a = '0; mul_b = '0; mul_sub = 1'b0;
      end
    endcase
  end

  assign mul_prod = PW'(mul_a) * PW'(mul_b);
  assign mac_add  = SW'(mul_prod);
  assign mac_sum  = mul_sub ? (sum_r - mac_add) : (sum_r + mac_add);

  assign in_x     = in_req.point_x[CW-1:0];
  assign in_y     = in_req.point_y[CW-1:0];
  assign in_y_ext = YW'(in_y);

  assign div_v = {height_r, 1'b0};
  // quotient must fit below 4096, so mag < div << 12 is part of qualifying
  assign qual  = (cnt_r < CNT_LIMIT) && (height_r != '0) && (height_r > min_height_r) &&
                 (mag_r > SW'({min_area_r, 1'b0})) && (mag_r < SW'({div_v, {QW{1'b0}}}));
  assign trial = {1'b0, mag_r[RW-1:0]} - {1'b0, dsh_r};

  always_comb begin
    state_nxt      = state_r;
    min_height_nxt = min_height_r;
    max_width_nxt  = max_width_r;
    min_area_nxt   = min_area_r;
    run_min_nxt    = run_min_r;
    run_max_nxt    = run_max_r;
    sum_nxt        = sum_r;
    at_start_nxt   = at_start_r;
    cnt_nxt        = cnt_r;
    best_valid_nxt = best_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    end_nxt        = end_r;
    fend_nxt       = fend_r;
    mag_nxt        = mag_r;
    height_nxt     = height_r;
    dsh_nxt        = dsh_r;
    quot_nxt       = quot_r;
    step_nxt       = step_r;
    best_idx_nxt   = best_idx_r;
    best_w_nxt     = best_w_r;
    best_top_nxt   = best_top_r;
    best_bot_nxt   = best_bot_r;
    out_nxt        = out_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        chws_pkg::REG_MIN_HEIGHT: min_height_nxt = cfg_wdata[YW-1:0];
        chws_pkg::REG_MAX_WIDTH:  max_width_nxt  = cfg_wdata[YW-1:0];
        chws_pkg::REG_MIN_AREA:   min_area_nxt   = cfg_wdata[chws_pkg::AREA_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_x_nxt = in_x;
          cur_y_nxt = in_y;
          end_nxt   = in_req.contour_end || in_req.frame_end;
          fend_nxt  = in_req.frame_end;
          if (in_y_ext < run_min_r) run_min_nxt = in_y_ext;
          if (in_y_ext > run_max_r) run_max_nxt = in_y_ext;
          if (at_start_r) begin
            first_x_nxt  = in_x;
            first_y_nxt  = in_y;
            prev_x_nxt   = in_x;
            prev_y_nxt   = in_y;
            at_start_nxt = 1'b0;
            state_nxt    = (in_req.contour_end || in_req.frame_end) ? S_CLS_A : S_IDLE;
          end else begin
            state_nxt = S_MUL_A;
          end
        end
      end
      S_MUL_A: begin
        sum_nxt   = mac_sum;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        sum_nxt    = mac_sum;
        prev_x_nxt = cur_x_r;
        prev_y_nxt = cur_y_r;
        state_nxt  = end_r ? S_CLS_A : S_IDLE;
      end
      S_CLS_A: begin
        sum_nxt   = mac_sum;
        state_nxt = S_CLS_B;
      end
      S_CLS_B: begin
        sum_nxt   = mac_sum;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        // twice the area is the magnitude of the two's-complement sum
        mag_nxt    = sum_r[SW-1] ? (~sum_r + SW'(1)) : sum_r;
        height_nxt = (run_max_r >= run_min_r) ? (run_max_r - run_min_r) : '0;
        state_nxt  = S_QUAL;
      end
      S_QUAL: begin
        dsh_nxt   = RW'({div_v, {(QW-1){1'b0}}});
        quot_nxt  = '0;
        step_nxt  = STW'(QW - 1);
        state_nxt = qual ? S_DIV : S_END;
      end
      S_DIV: begin
        // restoring divide of 2*area by 2*height, one quotient bit per cycle
        if (!trial[RW]) begin
          mag_nxt = SW'(trial[RW-1:0]);
        end
        quot_nxt = {quot_r[QW-2:0], !trial[RW]};
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r - STW'(1);
        if (step_r == '0) state_nxt = S_UPD;
      end
      S_UPD: begin
        if ((quot_r < max_width_r) && (!best_valid_r || (quot_r > best_w_r))) begin
          best_valid_nxt = 1'b1;
          best_idx_nxt   = cnt_r[chws_pkg::INDEX_W-1:0];
          best_w_nxt     = quot_r;
          best_top_nxt   = run_min_r;
          best_bot_nxt   = run_max_r;
        end
        state_nxt = S_END;
      end
      S_END: begin
        if (cnt_r < CNT_LIMIT) cnt_nxt = cnt_r + NW'(1);
        run_min_nxt  = MIN_Y_RST;
        run_max_nxt  = '0;
        sum_nxt      = '0;
        at_start_nxt = 1'b1;
        state_nxt    = fend_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // wait for the result register to free up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_nxt.found      = best_valid_r;
          out_nxt.best_index = best_valid_r ? best_idx_r : '0;
          out_nxt.best_width = best_valid_r ? best_w_r : '0;
          out_nxt.top_y      = best_valid_r ? best_top_r : '0;
          out_nxt.bottom_y   = best_valid_r ? best_bot_r : '0;
          cnt_nxt            = '0;
          best_valid_nxt     = 1'b0;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_height_r <= chws_pkg::MIN_HEIGHT_RST;
      max_width_r  <= chws_pkg::MAX_WIDTH_RST;
      min_area_r   <= chws_pkg::MIN_AREA_RST;
      run_min_r    <= MIN_Y_RST;
      run_max_r    <= '0;
      sum_r        <= '0;
      at_start_r   <= 1'b1;
      cnt_r        <= '0;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      min_height_r <= min_height_nxt;
      max_width_r  <= max_width_nxt;
      min_area_r   <= min_area_nxt;
      run_min_r    <= run_min_nxt;
      run_max_r    <= run_max_nxt;
      sum_r        <= sum_nxt;
      at_start_r   <= at_start_nxt;
      cnt_r        <= cnt_nxt;
      best_valid_r <= best_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    first_x_r  <= first_x_nxt;
    first_y_r  <= first_y_nxt;
    prev_x_r   <= prev_x_nxt;
    prev_y_r   <= prev_y_nxt;
    end_r      <= end_nxt;
    fend_r     <= fend_nxt;
    mag_r      <= mag_nxt;
    height_r   <= height_nxt;
    dsh_r      <= dsh_nxt;
    quot_r     <= quot_nxt;
    step_r     <= step_nxt;
    best_idx_r <= best_idx_nxt;
    best_w_r   <= best_w_nxt;
    best_top_r <= best_top_nxt;
    best_bot_r <= best_bot_nxt;
    out_r      <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_req   = out_r;

endmodule

`default_nettype wire
